/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/smc_pkg.sv */
// Types, constants and helper functions of the structured mesh connectivity block.
`default_nettype none

package smc_pkg;

  localparam int MAX_LOCAL_ZONES  = 1024;
  localparam int MAX_GLOBAL_ZONES = 4096;

  localparam int COORD_W     = 11;
  localparam int GCOORD_W    = 13;
  localparam int INDEX_W     = 31;
  localparam int GID_W       = 37;
  localparam int SLOT_W      = 3;
  localparam int NSLOT       = 8;
  localparam int CFG_DATA_W  = 26;
  localparam int CFG_INDEX_W = 4;
  localparam int PLANE_W     = 22;
  localparam int GPLANE_W    = 26;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THREE_D        = 4'd0,
    REG_ZONES_I        = 4'd1,
    REG_ZONES_J        = 4'd2,
    REG_ZONES_K        = 4'd3,
    REG_GLOBAL_ZONES   = 4'd4,
    REG_GLOBAL_START_I = 4'd5,
    REG_GLOBAL_START_J = 4'd6,
    REG_GLOBAL_START_K = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    OP_NODE = 1'b0,
    OP_ZONE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] coord_i;
    logic [COORD_W-1:0] coord_j;
    logic [COORD_W-1:0] coord_k;
  } query_t;

  typedef struct packed {
    logic [INDEX_W-1:0] neighbor_index;
    logic [GID_W-1:0]   global_node_id;
    logic [SLOT_W-1:0]  slot;
    logic               last;
    logic               range_error;
  } result_t;

  // One query, reduced to a base index, two strides and a mask of the slots to emit.
  typedef struct packed {
    op_e                op;
    logic               err;
    logic [NSLOT-1:0]   mask;
    logic [INDEX_W-1:0] base;
    logic [GID_W-1:0]   gid;
    logic [PLANE_W-1:0] p_stride;
    logic [COORD_W-1:0] k_stride;
  } job_t;

  function automatic logic [COORD_W-1:0] local_count(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v == '0) begin
      r = COORD_W'(1);
    end else if (v > COORD_W'(MAX_LOCAL_ZONES)) begin
      r = COORD_W'(MAX_LOCAL_ZONES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [GCOORD_W-1:0] global_clamp(input logic [GCOORD_W-1:0] v);
    return (v > GCOORD_W'(MAX_GLOBAL_ZONES)) ? GCOORD_W'(MAX_GLOBAL_ZONES) : v;
  endfunction

  // Corner offsets of a zone as {di, dj, dk}.
  function automatic logic [2:0] zone_corner(input logic [SLOT_W-1:0] slot);
    logic [2:0] d;
    unique case (slot)
      3'd0:    d = 3'b000;
      3'd1:    d = 3'b010;
      3'd2:    d = 3'b110;
      3'd3:    d = 3'b100;
      3'd4:    d = 3'b001;
      3'd5:    d = 3'b011;
      3'd6:    d = 3'b111;
      default: d = 3'b101;
    endcase
    return d;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [NSLOT-1:0] onehot);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int n = 0; n < NSLOT; n++) begin
      if (onehot[n]) begin
        s = s | SLOT_W'(n);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/smc_emit.sv */
// Result sequencer: walks the slot mask of one query and registers one result a cycle.
`default_nettype none

module smc_emit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire smc_pkg::job_t    job,
  input  wire logic             job_valid,
  output logic                  ready,
  output smc_pkg::result_t      result,
  output logic                  result_strobe
);

  logic                                 em_valid;
  logic [smc_pkg::NSLOT-1:0]            em_mask;
  smc_pkg::op_e                         em_op;
  logic                                 em_err;
  logic [smc_pkg::INDEX_W-1:0]          em_base;
  logic [smc_pkg::GID_W-1:0]            em_gid;
  logic [smc_pkg::PLANE_W-1:0]          em_p;
  logic [smc_pkg::COORD_W-1:0]          em_k;

  logic [smc_pkg::NSLOT-1:0]            low;
  logic [smc_pkg::NSLOT-1:0]            rest;
  logic [smc_pkg::SLOT_W-1:0]           slot;
  logic [2:0]                           delta;
  logic [smc_pkg::INDEX_W-1:0]          p_ext;
  logic [smc_pkg::INDEX_W-1:0]          k_ext;
  logic [smc_pkg::INDEX_W-1:0]          term_i;
  logic [smc_pkg::INDEX_W-1:0]          term_j;
  logic [smc_pkg::INDEX_W-1:0]          term_k;
  logic [smc_pkg::INDEX_W-1:0]          idx;
  logic                                 is_zone;

  // Lowest remaining slot goes out first, which keeps the fixed table order.
  assign low     = em_mask & (~em_mask + smc_pkg::NSLOT'(1));
  assign rest    = em_mask & ~low;
  assign slot    = smc_pkg::slot_of(low);
  assign is_zone = (em_op == smc_pkg::OP_ZONE);
  assign delta   = is_zone ? smc_pkg::zone_corner(slot) : slot;
  assign ready   = !em_valid || (rest == '0);

  assign p_ext = {{(smc_pkg::INDEX_W - smc_pkg::PLANE_W){1'b0}}, em_p};
  assign k_ext = {{(smc_pkg::INDEX_W - smc_pkg::COORD_W){1'b0}}, em_k};

  // Node queries step back by one zone where the offset bit is clear.
  always_comb begin
    if (is_zone) begin
      term_i = delta[2] ? p_ext : '0;
      term_j = delta[1] ? k_ext : '0;
      term_k = delta[0] ? smc_pkg::INDEX_W'(1) : '0;
    end else begin
      term_i = delta[2] ? '0 : ('0 - p_ext);
      term_j = delta[1] ? '0 : ('0 - k_ext);
      term_k = delta[0] ? '0 : '1;
    end
  end

  assign idx = em_base + term_i + term_j + term_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid      <= 1'b0;
      em_mask       <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= em_valid;
      if (em_valid && (rest != '0)) begin
        em_mask <= rest;
      end else if (job_valid) begin
        em_valid <= 1'b1;
        em_mask  <= job.mask;
      end else begin
        em_valid <= 1'b0;
        em_mask  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && job_valid) begin
      em_op   <= job.op;
      em_err  <= job.err;
      em_base <= job.base;
      em_gid  <= job.gid;
      em_p    <= job.p_stride;
      em_k    <= job.k_stride;
    end
    result.neighbor_index <= em_err ? '0 : idx;
    result.global_node_id <= em_gid;
    result.slot           <= slot;
    result.last           <= (rest == '0);
    result.range_error    <= em_err;
  end

endmodule

`default_nettype wire

/* sv/structured_mesh_connectivity.sv */
// Top level of the structured mesh connectivity generator.
//
// A query beat is taken at a rising edge with start high and busy low. Results leave on
// result, one per cycle, each marked by result_strobe for exactly one cycle; the receiver
// cannot hold them off, so it must take every beat as it comes. A query passes the
// pipeline stages, is loaded into the result sequencer and leaves through its registered
// result port. A query gives one to eight results (eight for a 3D zone query), which
// the result sequencer at the end of the pipeline emits back to back; it takes the next
// query only as the last result of the current one goes out. Queries enter on consecutive
// cycles while the five pipeline stages have room; busy rises only when the last stage
// holds a query that the sequencer cannot yet take, and then the whole pipeline holds still.
// Configuration registers are written by cfg_write, cfg_index and cfg_data and take effect
// on the next accepted query; they should only change while no query is in flight. A write
// to an index beyond the register list is ignored.
`default_nettype none

module structured_mesh_connectivity (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire smc_pkg::query_t                    query,
  output smc_pkg::result_t                        result,
  output logic                                    result_strobe,
  input  wire logic                               cfg_write,
  input  wire logic [smc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [smc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = smc_pkg::COORD_W;
  localparam int GW = smc_pkg::GCOORD_W;
  localparam int IW = smc_pkg::INDEX_W;
  localparam int DW = smc_pkg::GID_W;
  localparam int PW = smc_pkg::PLANE_W;
  localparam int QW = smc_pkg::GPLANE_W;
  localparam int NS = smc_pkg::NSLOT;

  // Configuration registers.
  logic                             three_d;
  logic [CW-1:0]                    zones_i;
  logic [CW-1:0]                    zones_j;
  logic [CW-1:0]                    zones_k;
  logic [smc_pkg::CFG_DATA_W-1:0]   global_zones_jk;
  logic [GW-1:0]                    global_start_i;
  logic [GW-1:0]                    global_start_j;
  logic [GW-1:0]                    global_start_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d         <= 1'b1;
      zones_i         <= CW'(1);
      zones_j         <= CW'(1);
      zones_k         <= CW'(1);
      global_zones_jk <= '0;
      global_start_i  <= '0;
      global_start_j  <= '0;
      global_start_k  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        smc_pkg::REG_THREE_D:        three_d         <= cfg_data[0];
        smc_pkg::REG_ZONES_I:        zones_i         <= cfg_data[CW-1:0];
        smc_pkg::REG_ZONES_J:        zones_j         <= cfg_data[CW-1:0];
        smc_pkg::REG_ZONES_K:        zones_k         <= cfg_data[CW-1:0];
        smc_pkg::REG_GLOBAL_ZONES:   global_zones_jk <= cfg_data;
        smc_pkg::REG_GLOBAL_START_I: global_start_i  <= cfg_data[GW-1:0];
        smc_pkg::REG_GLOBAL_START_J: global_start_j  <= cfg_data[GW-1:0];
        smc_pkg::REG_GLOBAL_START_K: global_start_k  <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Every stage moves together; the sequencer's ready decides.
  logic advance;
  logic em_ready;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;

  assign advance = !s5_valid || em_ready;
  assign busy    = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Stage 1: capture the query with the clamped mesh sizes and global offsets.
  // In 2D the third axis collapses to a single zone, a single node layer and offset zero.
  smc_pkg::op_e s1_op;
  logic [CW-1:0] s1_ci, s1_cj, s1_ck, s1_zi, s1_zj, s1_zk;
  logic          s1_d3;
  logic [GW-1:0] s1_gnj, s1_gnk, s1_gsi, s1_gsj, s1_gsk;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op  <= query.op;
      s1_ci  <= query.coord_i;
      s1_cj  <= query.coord_j;
      s1_ck  <= query.coord_k;
      s1_d3  <= three_d;
      s1_zi  <= smc_pkg::local_count(zones_i);
      s1_zj  <= smc_pkg::local_count(zones_j);
      s1_zk  <= three_d ? smc_pkg::local_count(zones_k) : CW'(1);
      s1_gnj <= smc_pkg::global_clamp(global_zones_jk[2*GW-1:GW]) + GW'(1);
      s1_gnk <= three_d ? (smc_pkg::global_clamp(global_zones_jk[GW-1:0]) + GW'(1))
                        : GW'(1);
      s1_gsi <= smc_pkg::global_clamp(global_start_i);
      s1_gsj <= smc_pkg::global_clamp(global_start_j);
      s1_gsk <= three_d ? smc_pkg::global_clamp(global_start_k) : '0;
    end
  end

  // Stage 2: range check, slot mask, strides and global coordinates.
  logic [CW-1:0] s1_nk;
  logic          s1_zone;
  logic          s1_err;
  logic [NS-1:0] s1_node_mask;
  logic [NS-1:0] s1_mask;
  logic [1:0]    va, vb, vc;

  assign s1_nk   = s1_d3 ? (s1_zk + CW'(1)) : CW'(1);
  assign s1_zone = (s1_op == smc_pkg::OP_ZONE);
  assign s1_err  = s1_zone ? ((s1_ci >= s1_zi) || (s1_cj >= s1_zj) || (s1_ck >= s1_zk))
                           : ((s1_ci >  s1_zi) || (s1_cj >  s1_zj) || (s1_ck >= s1_nk));

  // For a node, the zone one step back on an axis exists when the coordinate is non-zero,
  // and the zone straight ahead exists when the coordinate is below the zone count.
  assign va = {s1_ci < s1_zi, s1_ci != '0};
  assign vb = {s1_cj < s1_zj, s1_cj != '0};
  assign vc = {s1_ck < s1_zk, s1_ck != '0};

  always_comb begin
    for (int n = 0; n < NS; n++) begin
      s1_node_mask[n] = va[n[2]] & vb[n[1]] & vc[n[0]];
    end
  end

  always_comb begin
    if (s1_err) begin
      s1_mask = NS'(1);
    end else if (s1_zone) begin
      s1_mask = s1_d3 ? '1 : NS'(8'h0F);
    end else begin
      s1_mask = s1_node_mask;
    end
  end

  smc_pkg::op_e s2_op;
  logic          s2_err;
  logic [NS-1:0] s2_mask;
  logic [CW-1:0] s2_ci, s2_cj, s2_ck, s2_pj, s2_pk;
  logic [GW-1:0] s2_gi, s2_gj, s2_gk, s2_gnj, s2_gnk;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op   <= s1_op;
      s2_err  <= s1_err;
      s2_mask <= s1_mask;
      s2_ci   <= s1_ci;
      s2_cj   <= s1_cj;
      s2_ck   <= s1_ck;
      // Zone queries index nodes, node queries index zones.
      s2_pj   <= s1_zone ? (s1_zj + CW'(1)) : s1_zj;
      s2_pk   <= s1_zone ? s1_nk : s1_zk;
      s2_gi   <= s1_gsi + GW'(s1_ci);
      s2_gj   <= s1_gsj + GW'(s1_cj);
      s2_gk   <= s1_gsk + GW'(s1_ck);
      s2_gnj  <= s1_gnj;
      s2_gnk  <= s1_gnk;
    end
  end

  // Stage 3: plane sizes and the global row term.
  smc_pkg::op_e s3_op;
  logic          s3_err;
  logic [NS-1:0] s3_mask;
  logic [CW-1:0] s3_ci, s3_cj, s3_ck, s3_k;
  logic [PW-1:0] s3_p;
  logic [QW-1:0] s3_gjk, s3_gjt;
  logic [GW-1:0] s3_gi, s3_gk;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_op   <= s2_op;
      s3_err  <= s2_err;
      s3_mask <= s2_mask;
      s3_ci   <= s2_ci;
      s3_cj   <= s2_cj;
      s3_ck   <= s2_ck;
      s3_k    <= s2_pk;
      s3_p    <= PW'(s2_pj) * PW'(s2_pk);
      s3_gjk  <= QW'(s2_gnj) * QW'(s2_gnk);
      s3_gjt  <= QW'(s2_gj) * QW'(s2_gnk);
      s3_gi   <= s2_gi;
      s3_gk   <= s2_gk;
    end
  end

  // Stage 4: the plane and row products. The two plane products wrap harmlessly at the field widths.
  logic [IW+1:0]      s3_ap_full;
  logic [DW+1:0]      s3_git_full;
  logic [2*CW-1:0]    s3_bk_full;

  assign s3_ap_full  = (IW+2)'(s3_ci) * (IW+2)'(s3_p);
  assign s3_git_full = (DW+2)'(s3_gi) * (DW+2)'(s3_gjk);
  assign s3_bk_full  = (2*CW)'(s3_cj) * (2*CW)'(s3_k);

  smc_pkg::op_e s4_op;
  logic          s4_err;
  logic [NS-1:0] s4_mask;
  logic [IW-1:0] s4_ap;
  logic [2*CW-1:0] s4_bk;
  logic [CW-1:0] s4_ck, s4_k;
  logic [PW-1:0] s4_p;
  logic [DW-1:0] s4_git;
  logic [QW-1:0] s4_gjt;
  logic [GW-1:0] s4_gk;

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_op   <= s3_op;
      s4_err  <= s3_err;
      s4_mask <= s3_mask;
      s4_ap   <= s3_ap_full[IW-1:0];
      s4_bk   <= s3_bk_full;
      s4_ck   <= s3_ck;
      s4_k    <= s3_k;
      s4_p    <= s3_p;
      s4_git  <= s3_git_full[DW-1:0];
      s4_gjt  <= s3_gjt;
      s4_gk   <= s3_gk;
    end
  end

  // Stage 5: sum into the base index and the global node id. The base points at the
  // queried coordinates; the sequencer adds or subtracts the strides for each slot.
  smc_pkg::job_t s5_job;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_job.op       <= s4_op;
      s5_job.err      <= s4_err;
      s5_job.mask     <= s4_mask;
      s5_job.base     <= s4_ap + IW'(s4_bk) + IW'(s4_ck);
      s5_job.gid      <= (s4_err || (s4_op == smc_pkg::OP_ZONE)) ? '0
                         : (s4_git + DW'(s4_gjt) + DW'(s4_gk));
      s5_job.p_stride <= s4_p;
      s5_job.k_stride <= s4_k;
    end
  end

  smc_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .job           (s5_job),
    .job_valid     (s5_valid),
    .ready         (em_ready),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

`default_nettype wire

/* sv/smc_checker.sv */
// Port-level checks of the structured mesh connectivity block and their bind.
`default_nettype none
`include "assert_macros.svh"

module smc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             busy,
  input wire smc_pkg::result_t result,
  input wire logic             result_strobe
);

  `ASSERT_ALWAYS(a_quiet_after_reset, rst |=> (!result_strobe && !busy), "beat or busy after reset")

  `ASSERT_CLKD(a_error_beat_alone, (result_strobe && result.range_error) |-> (result.last && (result.slot == '0) && (result.neighbor_index == '0)), "range error beat malformed")

  `ASSERT_CLKD(a_slots_rise, (result_strobe && !result.last) |=> (result_strobe && (result.slot > $past(result.slot))), "query beats not contiguous in slot order")

  `ASSERT_CLKD(a_gid_steady, (result_strobe && !result.last) |=> (result.global_node_id == $past(result.global_node_id)), "global node id changed within a query")

endmodule

bind structured_mesh_connectivity smc_checker u_smc_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .result        (result),
  .result_strobe (result_strobe)
);

`default_nettype wire

/* tb/structured_mesh_connectivity_tb.sv */
// Self-checking testbench for the structured mesh connectivity generator.
`timescale 1ns / 1ps

module structured_mesh_connectivity_tb;
  import smc_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  // Margin after the owed results are out, before a register write or the end of the run.
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_LIMIT    = 4000;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTINGS_PER_MODE = 3;
  localparam int QUERIES_PER_SETTING = 28;
  localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_REG =
    CFG_INDEX_W'(REG_GLOBAL_START_K) + 1'b1;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  query_t                 query;
  result_t                result;
  logic                   result_strobe;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Our own copy of the register file, kept in step with every write we issue.
  bit                  mesh_is_3d   = 1'b1;
  bit [COORD_W-1:0]    span_i       = 1;
  bit [COORD_W-1:0]    span_j       = 1;
  bit [COORD_W-1:0]    span_k       = 1;
  bit [CFG_DATA_W-1:0] global_spans = '0;
  bit [GCOORD_W-1:0]   origin_i     = '0;
  bit [GCOORD_W-1:0]   origin_j     = '0;
  bit [GCOORD_W-1:0]   origin_k     = '0;

  // Connectivity results still owed by the block, oldest first.
  result_t link_queue[$];

  int fail_count       = 0;
  int queries_sent     = 0;
  int links_checked    = 0;
  int settings_applied = 0;
  int idle_pct         = 0;

  structured_mesh_connectivity DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .query         (query),
    .result        (result),
    .result_strobe (result_strobe),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Safety net: a healthy run finishes in well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // A local zone count of zero behaves as one, and anything above the maximum
  // saturates at the maximum.
  function automatic longint unsigned local_span(bit [COORD_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LOCAL_ZONES) return MAX_LOCAL_ZONES;
    return v;
  endfunction

  // Global counts and global offsets saturate at the global maximum.
  function automatic longint unsigned global_span(bit [GCOORD_W-1:0] v);
    return (v > MAX_GLOBAL_ZONES) ? MAX_GLOBAL_ZONES : v;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic query_t make_query(op_e op, int ci, int cj, int ck);
    query_t q;
    q.op      = op;
    q.coord_i = COORD_W'(ci);
    q.coord_j = COORD_W'(cj);
    q.coord_k = COORD_W'(ck);
    return q;
  endfunction

  // Works out every result that one query produces under the present register
  // settings and appends them to the queue of results still owed.
  function automatic void derive_links(query_t q);
    result_t           batch[$];
    result_t           r;
    longint unsigned   zi, zj, zk, nj, nk, gnj, gnk, gid;
    longint unsigned   ci, cj, ck, di, dj, dk;
    longint signed     a, b, e;
    int                corners;
    bit                outside;

    zi = local_span(span_i);
    zj = local_span(span_j);
    zk = mesh_is_3d ? local_span(span_k) : 1;
    nj = zj + 1;
    nk = mesh_is_3d ? zk + 1 : 1;
    ci = q.coord_i;
    cj = q.coord_j;
    ck = q.coord_k;

    // Nodes run one further than zones on every axis; in 2D only layer zero exists.
    if (q.op == OP_NODE) begin
      outside = (ci > zi) || (cj > zj) || (ck >= nk);
    end else begin
      outside = (ci >= zi) || (cj >= zj) || (ck >= zk);
    end

    if (outside) begin
      r             = '0;
      r.last        = 1'b1;
      r.range_error = 1'b1;
      link_queue.insert(link_queue.size(), r);
      return;
    end

    if (q.op == OP_NODE) begin
      gnj = global_span(global_spans[25:13]) + 1;
      gnk = mesh_is_3d ? global_span(global_spans[12:0]) + 1 : 1;
      gid = (global_span(origin_i) + ci) * gnj * gnk
          + (global_span(origin_j) + cj) * gnk
          + (mesh_is_3d ? global_span(origin_k) : 0) + ck;
      // Each slot bit chooses offset 0 (set) or -1 (clear); i is the top bit,
      // k the bottom one, so k moves fastest through the eight candidates.
      for (int c = 0; c < NSLOT; c++) begin
        a = longint'(ci) + ((c >> 2) & 1) - 1;
        b = longint'(cj) + ((c >> 1) & 1) - 1;
        e = longint'(ck) + (c & 1) - 1;
        if (a >= 0 && a < longint'(zi) && b >= 0 && b < longint'(zj) &&
            e >= 0 && e < longint'(zk)) begin
          r                = '0;
          r.neighbor_index = INDEX_W'(a * zj * zk + b * zk + e);
          r.global_node_id = GID_W'(gid);
          r.slot           = SLOT_W'(c);
          batch.insert(batch.size(), r);
        end
      end
      // An in-range node always touches at least one zone.
      batch[batch.size() - 1].last = 1'b1;
    end else begin
      // Corners go round the bottom face, then the top face in the same order.
      corners = mesh_is_3d ? NSLOT : NSLOT / 2;
      for (int c = 0; c < corners; c++) begin
        di               = (c >> 1) & 1;
        dj               = ((c >> 1) ^ c) & 1;
        dk               = (c >> 2) & 1;
        r                = '0;
        r.neighbor_index = INDEX_W'((ci + di) * (nj * nk) + (cj + dj) * nk + ck + dk);
        r.slot           = SLOT_W'(c);
        r.last           = (c == corners - 1);
        batch.insert(batch.size(), r);
      end
    end

    foreach (batch[n]) link_queue.insert(link_queue.size(), batch[n]);
  endfunction

  // Every result beat is compared with the oldest one still owed. The receiver
  // cannot stall the block, so each strobe is a beat that must be taken at once.
  task automatic check_link(result_t got);
    result_t want;
    if (link_queue.size() == 0) begin
      note_failure($sformatf("result with none owed: idx %0d gid %0d slot %0d last %0b err %0b",
                             got.neighbor_index, got.global_node_id, got.slot,
                             got.last, got.range_error));
      return;
    end
    want = link_queue.pop_front();
    links_checked++;
    if (got.neighbor_index !== want.neighbor_index ||
        got.global_node_id !== want.global_node_id ||
        got.slot !== want.slot || got.last !== want.last ||
        got.range_error !== want.range_error) begin
      note_failure($sformatf({"mismatch: expected idx %0d gid %0d slot %0d last %0b err %0b,",
                              " got idx %0d gid %0d slot %0d last %0b err %0b"},
                             want.neighbor_index, want.global_node_id, want.slot,
                             want.last, want.range_error,
                             got.neighbor_index, got.global_node_id, got.slot,
                             got.last, got.range_error));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe === 1'b1) begin
      check_link(result);
    end
  end

  // Presents one query and holds it until the block takes it. Start is left high
  // so that a following query can go in on the very next cycle.
  task automatic send_query(query_t q);
    @(negedge clk);
    start = 1'b1;
    query = q;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    derive_links(q);
    queries_sent++;
  endtask

  // Random sender idling: once a gap opens, each further cycle stays idle with
  // the same probability, so gaps land on every phase of a query's results.
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every owed result has come out. Every query
  // gives at least one result, so an empty queue means nothing is in flight.
  task automatic quiesce();
    int waited;
    @(negedge clk);
    start  = 1'b0;
    waited = 0;
    while (link_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (link_queue.size() != 0) begin
      note_failure($sformatf("%0d owed results never arrived", link_queue.size()));
      link_queue.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, mirrored into our own register copy. Writes to indexes
  // beyond the register list must leave everything untouched.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    start     = 1'b0;
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_THREE_D:        mesh_is_3d   = value[0];
      REG_ZONES_I:        span_i       = value[COORD_W-1:0];
      REG_ZONES_J:        span_j       = value[COORD_W-1:0];
      REG_ZONES_K:        span_k       = value[COORD_W-1:0];
      REG_GLOBAL_ZONES:   global_spans = value;
      REG_GLOBAL_START_I: origin_i     = value[GCOORD_W-1:0];
      REG_GLOBAL_START_J: origin_j     = value[GCOORD_W-1:0];
      REG_GLOBAL_START_K: origin_k     = value[GCOORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Local counts: mostly small so that boundaries come up often, with zero,
  // oversized and exactly maximal counts mixed in.
  function automatic logic [CFG_DATA_W-1:0] random_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return $urandom_range((1 << COORD_W) - 1, MAX_LOCAL_ZONES + 1);
    if (r < 30) return MAX_LOCAL_ZONES;
    return $urandom_range(6, 1);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_origin();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return CFG_DATA_W'({GCOORD_W{1'b1}});
    if (r < 30) return '0;
    return CFG_DATA_W'($urandom_range((1 << GCOORD_W) - 1));
  endfunction

  // A coordinate along one axis, given the highest value that is in range there.
  function automatic logic [COORD_W-1:0] pick_coord(longint unsigned highest);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return COORD_W'(highest);
    if (r < 80) return COORD_W'($urandom_range(int'(highest)));
    if (r < 92) return COORD_W'(highest + 1);
    return COORD_W'($urandom);
  endfunction

  task automatic random_setting(bit flat);
    logic [CFG_DATA_W-1:0] gz;
    int unsigned           r;
    write_reg(REG_THREE_D, flat ? CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)
                                : CFG_DATA_W'($urandom) | CFG_DATA_W'(1));
    write_reg(REG_ZONES_I, random_span());
    write_reg(REG_ZONES_J, random_span());
    write_reg(REG_ZONES_K, random_span());
    r  = $urandom_range(99);
    gz = (r < 20) ? '1 : (r < 30) ? '0 : CFG_DATA_W'($urandom);
    write_reg(REG_GLOBAL_ZONES, gz);
    write_reg(REG_GLOBAL_START_I, random_origin());
    write_reg(REG_GLOBAL_START_J, random_origin());
    write_reg(REG_GLOBAL_START_K, random_origin());
    settings_applied++;
  endtask

  // Straight after reset the mesh is a single 3D zone with no global offset, so
  // each node touches exactly one zone and the zone has all eight corners.
  task automatic test_reset_state();
    settings_applied++;
    send_query(make_query(OP_NODE, 0, 0, 0));
    send_query(make_query(OP_NODE, 1, 1, 1));
    send_query(make_query(OP_NODE, 1, 0, 1));
    send_query(make_query(OP_ZONE, 0, 0, 0));
    send_query(make_query(OP_NODE, 2, 0, 0));
    send_query(make_query(OP_ZONE, 0, 1, 0));
    send_query(make_query(OP_NODE, (1 << COORD_W) - 1, (1 << COORD_W) - 1,
                          (1 << COORD_W) - 1));
    quiesce();
  endtask

  // Zero, oversized and all-ones register values, which the block must clamp.
  // The far corner node gives the largest global id of this setting.
  task automatic test_count_clamping();
    write_reg(REG_ZONES_I, '0);
    write_reg(REG_ZONES_J, CFG_DATA_W'((1 << COORD_W) - 1));
    write_reg(REG_ZONES_K, CFG_DATA_W'(MAX_LOCAL_ZONES + 1));
    write_reg(REG_GLOBAL_ZONES, '1);
    write_reg(REG_GLOBAL_START_I, CFG_DATA_W'({GCOORD_W{1'b1}}));
    write_reg(REG_GLOBAL_START_J, CFG_DATA_W'({GCOORD_W{1'b1}}));
    write_reg(REG_GLOBAL_START_K, CFG_DATA_W'({GCOORD_W{1'b1}}));
    settings_applied++;
    send_query(make_query(OP_NODE, 1, MAX_LOCAL_ZONES, MAX_LOCAL_ZONES));
    send_query(make_query(OP_ZONE, 0, MAX_LOCAL_ZONES - 1, MAX_LOCAL_ZONES - 1));
    send_query(make_query(OP_NODE, 0, MAX_LOCAL_ZONES + 1, 0));
    send_query(make_query(OP_ZONE, 1, 0, 0));
    send_query(make_query(OP_NODE, 0, MAX_LOCAL_ZONES / 2, 0));
    quiesce();
  endtask

  // 2D mesh: the third-axis count, global count and offset are all ignored and
  // any non-zero k coordinate is out of range. Upper data bits of the mode
  // register are set to show that only bit zero counts.
  task automatic test_flat_mesh();
    write_reg(REG_THREE_D, '1 & ~CFG_DATA_W'(1));
    write_reg(REG_ZONES_I, 3);
    write_reg(REG_ZONES_J, 2);
    write_reg(REG_ZONES_K, 700);
    write_reg(REG_GLOBAL_ZONES, {13'd9, 13'd5});
    write_reg(REG_GLOBAL_START_I, 4);
    write_reg(REG_GLOBAL_START_J, 7);
    write_reg(REG_GLOBAL_START_K, 100);
    settings_applied++;
    send_query(make_query(OP_NODE, 1, 1, 0));
    send_query(make_query(OP_NODE, 3, 2, 0));
    send_query(make_query(OP_NODE, 0, 0, 1));
    send_query(make_query(OP_ZONE, 2, 1, 0));
    send_query(make_query(OP_ZONE, 0, 0, 1));
    quiesce();
  endtask

  // Writes to every index past the register list, then an interior node with
  // all eight neighbours and the far zone to show nothing was disturbed.
  task automatic test_spare_registers();
    write_reg(REG_THREE_D, 1);
    write_reg(REG_ZONES_I, 4);
    write_reg(REG_ZONES_J, 4);
    write_reg(REG_ZONES_K, 4);
    for (int idx = FIRST_SPARE_REG; idx < (1 << CFG_INDEX_W); idx++) begin
      write_reg(CFG_INDEX_W'(idx), CFG_DATA_W'($urandom));
    end
    settings_applied++;
    send_query(make_query(OP_NODE, 2, 2, 2));
    send_query(make_query(OP_ZONE, 3, 3, 3));
    quiesce();
  endtask

  // Random queries over several random settings, one of them 2D. Halfway
  // through each setting the sender stops until every owed result is out.
  task automatic test_random_traffic(int pct);
    query_t          q;
    longint unsigned zi, zj, zk;
    idle_pct = pct;
    for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
      random_setting(s == 1);
      zi = local_span(span_i);
      zj = local_span(span_j);
      zk = mesh_is_3d ? local_span(span_k) : 1;
      for (int n = 0; n < QUERIES_PER_SETTING; n++) begin
        if (n == QUERIES_PER_SETTING / 2) quiesce();
        q.op = op_e'($urandom_range(1));
        if (q.op == OP_NODE) begin
          q.coord_i = pick_coord(zi);
          q.coord_j = pick_coord(zj);
          q.coord_k = pick_coord(mesh_is_3d ? zk : 0);
        end else begin
          q.coord_i = pick_coord(zi - 1);
          q.coord_j = pick_coord(zj - 1);
          q.coord_k = pick_coord(zk - 1);
        end
        send_query(q);
        sender_gap();
      end
      quiesce();
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    query     = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_count_clamping();
    test_flat_mesh();
    test_spare_registers();
    test_random_traffic(26);
    test_random_traffic(81);
    test_random_traffic(0);

    $display("Sent %0d node and zone queries over %0d register settings, 2D and 3D,",
             queries_sent, settings_applied);
    $display("with sender idling at 26%%, 81%% and none; %0d result beats checked, %0d failures.",
             links_checked, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/smc_pkg.sv
sv/smc_emit.sv
sv/structured_mesh_connectivity.sv
sv/smc_checker.sv
tb/structured_mesh_connectivity_tb.sv
